### src/shift_page_decoder_core_defines.svh
// ---------------------------------------------------------------------------
// shift page decoder assertion macros
// assertion helpers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef SHIFT_PAGE_DECODER_CORE_DEFINES_SVH
`define SHIFT_PAGE_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SPD_ASSERT_IMP(label, clk_s, rst_s, a, c) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (a) |-> (c)) \
    else $error("assertion failed");
`define SPD_ASSERT_NXT(label, clk_s, rst_s, a, c) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SPD_ASSERT_IMP(label, clk_s, rst_s, a, c)
`define SPD_ASSERT_NXT(label, clk_s, rst_s, a, c)
`endif
`endif

### src/spd_pkg.sv
// ---------------------------------------------------------------------------
// spd_pkg
// types and constants shared by the shift page decoder
// ---------------------------------------------------------------------------
`default_nettype none
package spd_pkg;
  localparam logic [2:0] ACT_STD   = 3'd0;
  localparam logic [2:0] ACT_PRIV  = 3'd1;
  localparam logic [2:0] ACT_DEQ   = 3'd2;
  localparam logic [2:0] ACT_CLR   = 3'd3;
  localparam logic [2:0] ACT_TICK  = 3'd4;
  localparam logic [7:0] PG_STATUS = 8'h01;
  localparam logic [7:0] PG_BATT   = 8'h52;
  localparam logic [7:0] PG_PGEAR  = 8'h00;
  localparam logic [7:0] PG_PTOT   = 8'h11;
  localparam logic       CFG_STALE = 1'b0;
  localparam logic       CFG_REQ   = 1'b1;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] page_bytes;
    logic [31:0] now_ms;
    logic        link_live;
  } spd_in_t;

  typedef struct packed {
    logic        change_got;
    logic [11:0] change_record;
    logic [2:0]  front_gear;
    logic [4:0]  rear_gear;
    logic [5:0]  status_flags;
    logic [2:0]  front_count;
    logic [4:0]  rear_count;
    logic [15:0] shift_count;
    logic [11:0] battery_volts_q8;
    logic [2:0]  battery_status;
    logic [6:0]  battery_percent;
    logic        request_sysinfo;
  } spd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_SCAN, ST_SUM, ST_DONE
  } spd_state_t;

  typedef struct packed {
    logic exec;
    logic scan;
    logic write_slot;
    logic sum;
    logic emit;
    logic clear;
  } spd_cmd_t;

  typedef struct packed {
    logic is_batt;
    logic last;
  } spd_stat_t;
endpackage
`default_nettype wire

### src/spd_ram.sv
// ---------------------------------------------------------------------------
// spd_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none
module spd_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### src/spd_ctrl.sv
// ---------------------------------------------------------------------------
// spd_ctrl
// sequencer: exec, battery slot scan, summary scan, emit
// ---------------------------------------------------------------------------
`default_nettype none
module spd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire spd_pkg::spd_stat_t stat,
  output spd_pkg::spd_cmd_t      cmd
);
  import spd_pkg::*;
  spd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cmd.clear = start;
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.is_batt) state_nxt = ST_SCAN;
        else state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.last) begin
          cmd.write_slot = 1'b1;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        if (stat.last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.emit = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### src/spd_dp.sv
// ---------------------------------------------------------------------------
// spd_dp
// decoder datapath: gear state, battery table, change queue, request timer
// ---------------------------------------------------------------------------
`default_nettype none
module spd_dp #(
  parameter int BATTERY_SLOTS = 4,
  parameter int QUEUE_DEPTH   = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire spd_pkg::spd_in_t  in_data,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire spd_pkg::spd_cmd_t cmd,
  output spd_pkg::spd_stat_t     stat,
  output spd_pkg::spd_out_t      res
);
  import spd_pkg::*;
  localparam int SW = (BATTERY_SLOTS > 1) ? $clog2(BATTERY_SLOTS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [31:0] stale_r, period_r;
  spd_in_t     in_r;
  logic [2:0]  gf_r;
  logic [4:0]  gr_r;
  logic [3:0]  flags_r;
  logic [2:0]  tf_r;
  logic [4:0]  tr_r;
  logic [15:0] shifts_r;
  logic [11:0] volts_r;
  logic [2:0]  worst_r;
  logic [6:0]  pct_r;
  logic        bvalid_r;
  logic [31:0] last_page_r, last_req_r;
  logic        req_sent_r;
  logic [QW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic        got_r, ask_r;

  logic        used_r [BATTERY_SLOTS];
  logic [3:0]  sid_r  [BATTERY_SLOTS];
  logic [2:0]  sst_r  [BATTERY_SLOTS];
  logic [11:0] sv_r   [BATTERY_SLOTS];
  logic [SW-1:0] idx_r;
  logic        match_r, free_r;
  logic [SW-1:0] match_i_r, free_i_r;
  logic [11:0] minv_r;
  logic [2:0]  wst_r;

  // page fields
  logic [7:0] p0, p2, p3, p4, b6, b7;
  assign p0 = in_r.page_bytes[7:0];
  assign p2 = in_r.page_bytes[23:16];
  assign p3 = in_r.page_bytes[31:24];
  assign p4 = in_r.page_bytes[39:32];
  assign b6 = in_r.page_bytes[55:48];
  assign b7 = in_r.page_bytes[63:56];

  logic [31:0] page_age, req_age;
  assign page_age = in_r.now_ms - last_page_r;
  assign req_age  = in_r.now_ms - last_req_r;

  assign stat.is_batt = (in_r.action == ACT_STD) && (p0 == PG_BATT);
  assign stat.last    = (idx_r == SW'(BATTERY_SLOTS - 1));

  // gear decode
  logic       is_std_gear, is_priv_gear;
  logic [2:0] sfront;
  logic [4:0] srear, stot_rear;
  logic [2:0] stot_f;
  logic       rv, fv;
  logic [2:0] nf;
  logic [4:0] nr;
  logic       rmove, fmove, gear_act;
  logic [11:0] rec;
  always_comb begin
    sfront = p3[7:5];
    srear  = p3[4:0];
    stot_f = p4[7:5];
    stot_rear = p4[4:0];
    rv = (srear != 5'h1F) && (stot_rear != 5'd0) && (stot_rear >= srear);
    fv = (sfront != 3'h7) && (stot_f != 3'd0) && (stot_f >= sfront);
    is_std_gear  = (in_r.action == ACT_STD) && (p0 == PG_STATUS);
    is_priv_gear = (in_r.action == ACT_PRIV) && (p0 == PG_PGEAR);
    nf = '0;
    nr = '0;
    if (is_std_gear) begin
      nf = fv ? sfront + 3'd1 : 3'd0;
      nr = rv ? srear + 5'd1 : 5'd0;
    end else if (is_priv_gear) begin
      nf = (p2 > 8'd3) ? 3'd0 : p2[2:0];
      nr = (p3 > 8'd13) ? 5'd0 : p3[4:0];
    end
    rmove = (nr != 5'd0) && (!flags_r[2] || gr_r != nr);
    fmove = (nf != 3'd0) && (!flags_r[1] || gf_r != nf);
    gear_act = (is_std_gear || is_priv_gear) && (nr != 5'd0 || nf != 3'd0);
    rec = {nf != 3'd0, nr != 5'd0, fmove, rmove,
           (nf != 3'd0) ? nf : gf_r, (nr != 5'd0) ? nr : gr_r};
  end

  // change queue, circular over any depth
  logic          q_we, push;
  logic [QW-1:0] q_waddr, head_inc;
  logic [QW:0]   q_sum;
  logic [11:0]   q_rdata;
  assign push = cmd.exec && gear_act && (rmove || fmove);
  assign q_we = push;
  assign head_inc = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(head_r + 1'b1);
  assign q_sum = {1'b0, head_r} + (QW+1)'(count_r);
  assign q_waddr = (count_r == CW'(QUEUE_DEPTH)) ? head_r :
                   (q_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                   QW'(q_sum - (QW+1)'(QUEUE_DEPTH)) : q_sum[QW-1:0];
  // read data at head is registered on the exec edge and shown during emit
  spd_ram #(.WIDTH(12), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(rec),
    .raddr(head_r), .rdata(q_rdata)
  );

  logic [11:0] new_v;
  assign new_v = (b7[3:0] == 4'hF) ? 12'd0 : {b7[3:0], b6};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r <= 32'd5000; period_r <= 32'd10000;
      gf_r <= '0; gr_r <= '0; flags_r <= '0; tf_r <= '0; tr_r <= '0;
      shifts_r <= '0; volts_r <= '0; worst_r <= '0; pct_r <= '0; bvalid_r <= 1'b0;
      last_page_r <= '0; last_req_r <= '0; req_sent_r <= 1'b0;
      head_r <= '0; count_r <= '0; got_r <= 1'b0; ask_r <= 1'b0;
      idx_r <= '0;
      match_r <= 1'b0; free_r <= 1'b0;
      for (int i = 0; i < BATTERY_SLOTS; i++) used_r[i] <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_STALE) stale_r <= cfg_data;
        else period_r <= cfg_data;
      end
      if (start) in_r <= in_data;
      if (cmd.clear) begin
        got_r <= 1'b0; ask_r <= 1'b0; idx_r <= '0;
        match_r <= 1'b0; free_r <= 1'b0; minv_r <= '0; wst_r <= '0;
        match_i_r <= '0; free_i_r <= '0;
      end
      if (cmd.exec) begin
        case (in_r.action)
          ACT_STD, ACT_PRIV: begin
            last_page_r <= in_r.now_ms;
            if (in_r.action == ACT_PRIV) flags_r[3] <= 1'b1;
            if (is_std_gear) begin
              if (rv) tr_r <= stot_rear;
              if (fv) tf_r <= stot_f;
            end
            if (in_r.action == ACT_PRIV && p0 == PG_PGEAR && p4 != 8'd0 && p4 <= 8'd100) begin
              pct_r <= p4[6:0]; bvalid_r <= 1'b1;
            end
            if (in_r.action == ACT_PRIV && p0 == PG_PTOT) begin
              if (p2 != 8'd0 && p2 <= 8'd3) tf_r <= p2[2:0];
              if (p3 != 8'd0 && p3 <= 8'd13) tr_r <= p3[4:0];
            end
            if (is_std_gear || is_priv_gear) begin
              if (nr != 5'd0) gr_r <= nr;
              if (nf != 3'd0) gf_r <= nf;
              flags_r[1] <= (nf != 3'd0);
              flags_r[2] <= (nr != 5'd0);
              if (gear_act) flags_r[0] <= 1'b1;
              if (push) begin
                if (flags_r[0]) shifts_r <= shifts_r + 16'd1;
                if (count_r == CW'(QUEUE_DEPTH)) head_r <= head_inc;
                else count_r <= count_r + 1'b1;
              end
            end
          end
          ACT_DEQ: begin
            if (count_r != '0) begin
              got_r <= 1'b1;
              head_r <= head_inc;
              count_r <= count_r - 1'b1;
            end
          end
          ACT_CLR: begin
            head_r <= '0; count_r <= '0;
          end
          ACT_TICK: begin
            if (in_r.link_live && flags_r[3] && (tf_r == 3'd0 || tr_r == 5'd0) &&
                page_age < stale_r && (!req_sent_r || req_age >= period_r)) begin
              ask_r <= 1'b1; last_req_r <= in_r.now_ms; req_sent_r <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      // slot search, one slot a cycle
      if (cmd.scan) begin
        if (!match_r && used_r[idx_r] && sid_r[idx_r] == p2[7:4]) begin
          match_r <= 1'b1; match_i_r <= idx_r;
        end
        if (!free_r && !used_r[idx_r]) begin
          free_r <= 1'b1; free_i_r <= idx_r;
        end
        idx_r <= stat.last ? '0 : SW'(idx_r + 1'b1);
      end
      if (cmd.write_slot) begin
        logic [SW-1:0] ws;
        ws = '0;
        if (!match_r && used_r[idx_r] && sid_r[idx_r] == p2[7:4]) ws = idx_r;
        else if (match_r) ws = match_i_r;
        else if (free_r) ws = free_i_r;
        else if (!used_r[idx_r]) ws = idx_r;
        used_r[ws] <= 1'b1; sid_r[ws] <= p2[7:4];
        sst_r[ws] <= b7[6:4]; sv_r[ws] <= new_v;
      end
      // summary, one slot a cycle
      if (cmd.sum) begin
        logic [11:0] mv;
        logic [2:0]  wv;
        mv = minv_r; wv = wst_r;
        if (used_r[idx_r]) begin
          if (sv_r[idx_r] != 12'd0 && (mv == 12'd0 || sv_r[idx_r] < mv)) mv = sv_r[idx_r];
          if (sst_r[idx_r] >= 3'd1 && sst_r[idx_r] <= 3'd5 && sst_r[idx_r] > wv)
            wv = sst_r[idx_r];
        end
        minv_r <= mv; wst_r <= wv;
        idx_r <= stat.last ? '0 : SW'(idx_r + 1'b1);
        // battery valid follows the new summary, percent alone does not keep it
        if (stat.last) begin
          volts_r <= mv; worst_r <= wv;
          bvalid_r <= (mv != 12'd0 || wv != 3'd0);
        end
      end
    end
  end

  always_comb begin
    res.change_got       = got_r;
    res.change_record    = got_r ? q_rdata : 12'd0;
    res.front_gear       = gf_r;
    res.rear_gear        = gr_r;
    res.status_flags     = {bvalid_r, flags_r[0] && (page_age < stale_r), flags_r};
    res.front_count      = tf_r;
    res.rear_count       = tr_r;
    res.shift_count      = shifts_r;
    res.battery_volts_q8 = volts_r;
    res.battery_status   = worst_r;
    res.battery_percent  = pct_r;
    res.request_sysinfo  = ask_r;
  end
endmodule
`default_nettype wire

### src/shift_page_decoder_core.sv
// ---------------------------------------------------------------------------
// shift_page_decoder_core: shifting page decoder, start/busy in, strobed beat out
// the beat follows the exec state, or the exec, slot scan and summary states on a battery page
// a new item is taken only once the sequencer has emitted the beat and is back in idle
// rst_n is synchronous active low and clears gear, battery, queue and timer state
// ---------------------------------------------------------------------------
`default_nettype none
`include "shift_page_decoder_core_defines.svh"
module shift_page_decoder_core #(
  parameter int BATTERY_SLOTS = 4,
  parameter int QUEUE_DEPTH   = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire spd_pkg::spd_in_t in_data,
  output logic                  out_valid,
  output spd_pkg::spd_out_t     out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [31:0]      cfg_data
);
  import spd_pkg::*;

  spd_cmd_t  cmd;
  spd_stat_t stat;
  logic      accept;

  // an item is taken only while the sequencer is idle
  assign accept = start && !busy;

  spd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(accept), .busy(busy),
    .stat(stat), .cmd(cmd)
  );

  // datapath holds all decoder state and the registered result beat
  spd_dp #(.BATTERY_SLOTS(BATTERY_SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .start(accept), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .stat(stat), .res(out_data)
  );

  // result beat is valid for the single emit cycle, the receiver cannot stall it
  assign out_valid = cmd.emit;

  `SPD_ASSERT_NXT(a_busy_after_start, clk, rst_n, accept, busy)
  `SPD_ASSERT_IMP(a_emit_busy, clk, rst_n, out_valid, busy)
  `SPD_ASSERT_IMP(a_got_only_on_deq, clk, rst_n, out_valid && out_data.change_got,
                  out_data.request_sysinfo == 1'b0)
endmodule
`default_nettype wire
